[rtl/perceptron_classify_train_top_assert.svh]
// Assertion macros for the top level of the perceptron block.
`ifndef PERCEPTRON_CLASSIFY_TRAIN_TOP_ASSERT_SVH
`define PERCEPTRON_CLASSIFY_TRAIN_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/pct_pkg.sv]
`default_nettype none
package pct_pkg;

	localparam int MAX_FEATURES     = 8;
	localparam int NUM_FEATURES_DEF = 8;
	localparam int NUM_WEIGHTS      = 9;
	localparam logic [3:0] BIAS_IDX = 4'd8;
	localparam int SUM_W            = 36;
	localparam logic [15:0] LR_RESET = 16'd256;
	localparam logic signed [15:0] BIAS_X = 16'sd256;

	typedef enum logic [2:0] {
		CMD_CLASSIFY = 3'd0,
		CMD_TRAIN    = 3'd1,
		CMD_WRITE    = 3'd2,
		CMD_READ     = 3'd3,
		CMD_CLEAR    = 3'd4
	} cmd_t;

	localparam logic [1:0] ERR_ZERO = 2'b00;
	localparam logic [1:0] ERR_POS  = 2'b01;
	localparam logic [1:0] ERR_NEG  = 2'b11;

	typedef struct packed {
		logic adv1;
		logic adv2;
	} lane_ctl_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767)
			r = 16'sd32767;
		else if (v < -18'sd32768)
			r = -16'sd32768;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/pct_ifs.sv]
`default_nettype none
interface pct_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [15:0] feature_0;
	logic signed [15:0] feature_1;
	logic signed [15:0] feature_2;
	logic signed [15:0] feature_3;
	logic signed [15:0] feature_4;
	logic signed [15:0] feature_5;
	logic signed [15:0] feature_6;
	logic signed [15:0] feature_7;
	logic               label;
	logic [3:0]         weight_index;
	logic signed [15:0] weight_value;

	modport source (output valid, cmd, feature_0, feature_1, feature_2, feature_3,
		feature_4, feature_5, feature_6, feature_7, label, weight_index, weight_value,
		input ready);
	modport sink (input valid, cmd, feature_0, feature_1, feature_2, feature_3,
		feature_4, feature_5, feature_6, feature_7, label, weight_index, weight_value,
		output ready);
endinterface

interface pct_result_if;
	logic               valid;
	logic               ready;
	logic               class_out;
	logic signed [1:0]  error_out;
	logic signed [15:0] weight_out;
	logic [15:0]        examples_seen;
	logic [15:0]        examples_correct;

	modport source (output valid, class_out, error_out, weight_out, examples_seen,
		examples_correct, input ready);
	modport sink (input valid, class_out, error_out, weight_out, examples_seen,
		examples_correct, output ready);
endinterface

interface pct_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/perceptron_classify_train_top.sv]
// Perceptron classifier and trainer, one lane per feature plus a bias lane.
// item:   commands classify, train, write weight, read weight, clear counters,
//         with eight signed Q8.8 features, a label and a weight index and value.
// result: one transaction per item: class, error, weight read back and both
//         counters as they stand after the item.
// cfg:    learning rate (unsigned Q0.16), always ready, written while idle.
// Pipeline: an item passes the lane multiply, the merge adder tree, then
// decision and weight update, and its result then sits in the output register.
// Throughput: classify, read and clear items are taken one per cycle while the
// result side keeps up. Train and write items change the weights at the end of
// the decision stage, so the next item waits until they have left that stage.
// Reset: weights and counters go to zero, learning rate to 1/256, pipeline
// empty. When the result side stalls, the pipeline fills and then holds the
// item channel not ready; nothing is dropped.
`default_nettype none
`include "perceptron_classify_train_top_assert.svh"
module perceptron_classify_train_top #(
	parameter int NUM_FEATURES = pct_pkg::NUM_FEATURES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pct_item_if.sink   item,
	pct_result_if.source result,
	pct_cfg_if.sink    cfg
);
	import pct_pkg::*;

	localparam int NUM_LANES = NUM_FEATURES + 1;

	logic [15:0] lr_q;
	logic [NUM_WEIGHTS-1:0][15:0] weights_q;
	logic [15:0] seen_q, correct_q;

	logic valid_s1, valid_s2, out_valid_q;
	logic [2:0] cmd_s1, cmd_s2;
	logic label_s1, label_s2;
	logic [3:0] widx_s1, widx_s2;
	logic [15:0] wout_s1, wout_s2;

	logic class_q;
	logic [1:0] error_q;
	logic [15:0] wout_q;

	logic adv3, free2, free1, accept;
	logic wmod_s1, wmod_s2;
	lane_ctl_t ctl;

	logic signed [15:0] feat [MAX_FEATURES];
	logic signed [31:0] prod [NUM_LANES];
	logic signed [15:0] w_upd [NUM_LANES];
	logic pos;
	logic [15:0] rd_w;

	logic guess;
	logic [1:0] err_d;
	logic class_d;

	// handshake and pipeline advance
	always_comb begin
		wmod_s1  = (cmd_s1 == CMD_TRAIN) || (cmd_s1 == CMD_WRITE);
		wmod_s2  = (cmd_s2 == CMD_TRAIN) || (cmd_s2 == CMD_WRITE);
		adv3     = valid_s2 && (!out_valid_q || result.ready);
		free2    = !valid_s2 || adv3;
		ctl.adv2 = valid_s1 && free2;
		free1    = !valid_s1 || ctl.adv2;
		// hold new items while a weight change is still in flight
		item.ready = free1 && !(valid_s1 && wmod_s1) && !(valid_s2 && wmod_s2);
		accept   = item.valid && item.ready;
		ctl.adv1 = accept;
	end

	assign cfg.ready = 1'b1;

	always_comb begin
		feat[0] = item.feature_0;
		feat[1] = item.feature_1;
		feat[2] = item.feature_2;
		feat[3] = item.feature_3;
		feat[4] = item.feature_4;
		feat[5] = item.feature_5;
		feat[6] = item.feature_6;
		feat[7] = item.feature_7;
		rd_w = 16'd0;
		if (item.weight_index < 4'(NUM_WEIGHTS)) begin
			if (item.cmd == CMD_WRITE)
				rd_w = item.weight_value;
			else if (item.cmd == CMD_READ)
				rd_w = weights_q[item.weight_index];
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		if (l == NUM_FEATURES) begin : g_bias
			pct_lane u_lane (
				.clk        (clk),
				.ctl        (ctl),
				.x          (BIAS_X),
				.w          ($signed(weights_q[BIAS_IDX])),
				.learn_rate (lr_q),
				.err_neg    (!label_s2),
				.prod_s1    (prod[l]),
				.w_upd      (w_upd[l])
			);
		end else begin : g_feat
			pct_lane u_lane (
				.clk        (clk),
				.ctl        (ctl),
				.x          (feat[l]),
				.w          ($signed(weights_q[l])),
				.learn_rate (lr_q),
				.err_neg    (!label_s2),
				.prod_s1    (prod[l]),
				.w_upd      (w_upd[l])
			);
		end
	end

	pct_merge #(.NUM_LANES(NUM_LANES)) u_merge (
		.clk  (clk),
		.ctl  (ctl),
		.prod (prod),
		.pos  (pos)
	);

	// control valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			lr_q        <= LR_RESET;
		end else begin
			if (free1)
				valid_s1 <= accept;
			if (free2)
				valid_s2 <= ctl.adv2;
			if (adv3)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (cfg.valid)
				lr_q <= cfg.data;
		end
	end

	// item payload down the pipe
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= item.cmd;
			label_s1 <= item.label;
			widx_s1  <= item.weight_index;
			wout_s1  <= rd_w;
		end
		if (ctl.adv2) begin
			cmd_s2   <= cmd_s1;
			label_s2 <= label_s1;
			widx_s2  <= widx_s1;
			wout_s2  <= wout_s1;
		end
	end

	// decision
	always_comb begin
		guess   = pos;
		class_d = ((cmd_s2 == CMD_CLASSIFY) || (cmd_s2 == CMD_TRAIN)) ? guess : 1'b0;
		err_d   = ERR_ZERO;
		if (cmd_s2 == CMD_TRAIN) begin
			if (label_s2 && !guess)
				err_d = ERR_POS;
			else if (!label_s2 && guess)
				err_d = ERR_NEG;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			class_q <= class_d;
			error_q <= err_d;
			wout_q  <= wout_s2;
		end
	end

	// weights and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '0;
			seen_q    <= 16'd0;
			correct_q <= 16'd0;
		end else if (adv3) begin
			unique case (cmd_s2)
				CMD_TRAIN: begin
					if (seen_q != 16'hFFFF)
						seen_q <= seen_q + 16'd1;
					if (err_d == ERR_ZERO) begin
						if (correct_q != 16'hFFFF)
							correct_q <= correct_q + 16'd1;
					end else begin
						for (int i = 0; i < NUM_FEATURES; i++)
							weights_q[i] <= w_upd[i];
						weights_q[BIAS_IDX] <= w_upd[NUM_FEATURES];
					end
				end
				CMD_WRITE: begin
					if (widx_s2 < 4'(NUM_WEIGHTS))
						weights_q[widx_s2] <= wout_s2;
				end
				CMD_CLEAR: begin
					seen_q    <= 16'd0;
					correct_q <= 16'd0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		result.valid            = out_valid_q;
		result.class_out        = class_q;
		result.error_out        = error_q;
		result.weight_out       = wout_q;
		result.examples_seen    = seen_q;
		result.examples_correct = correct_q;
	end

	`PCT_ASSERT_IMPL(a_hazard_stall, clk, arst_n, (valid_s1 && wmod_s1) || (valid_s2 && wmod_s2), !item.ready, "item taken while a weight change is in flight")
	`PCT_ASSERT_IMPL(a_count_order, clk, arst_n, 1'b1, correct_q <= seen_q, "correct count exceeds seen count")
	`PCT_ASSERT_NEXT(a_weight_hold, clk, arst_n, !adv3, $stable(weights_q), "weights changed outside the decision stage")
	`PCT_ASSERT_NEXT(a_result_load, clk, arst_n, adv3, result.valid, "decision stage advanced without a result")

endmodule
`default_nettype wire

[rtl/pct_lane.sv]
`default_nettype none
module pct_lane (
	input  logic               clk,
	input  pct_pkg::lane_ctl_t ctl,
	input  logic signed [15:0] x,
	input  logic signed [15:0] w,
	input  logic [15:0]        learn_rate,
	input  logic               err_neg,
	output logic signed [31:0] prod_s1,
	output logic signed [15:0] w_upd
);
	import pct_pkg::*;

	logic [16:0]        mag_x;
	logic [32:0]        p_rnd;
	logic [16:0]        step_s1, step_s2;
	logic               xneg_s1, xneg_s2;
	logic signed [17:0] delta;
	logic signed [17:0] total;

	always_comb begin
		mag_x = x[15] ? (17'd0 - {x[15], x}) : {x[15], x};
		// round half away from zero back to Q8.8
		p_rnd = (33'(learn_rate) * 33'(mag_x)) + 33'd32768;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			prod_s1 <= 32'(x) * 32'(w);
			step_s1 <= p_rnd[32:16];
			xneg_s1 <= x[15];
		end
		if (ctl.adv2) begin
			step_s2 <= step_s1;
			xneg_s2 <= xneg_s1;
		end
	end

	always_comb begin
		delta = (xneg_s2 ^ err_neg) ? -$signed({1'b0, step_s2}) : $signed({1'b0, step_s2});
		total = 18'(w) + delta;
		w_upd = sat16(total);
	end

endmodule
`default_nettype wire

[rtl/pct_merge.sv]
`default_nettype none
module pct_merge #(
	parameter int NUM_LANES = pct_pkg::NUM_FEATURES_DEF + 1
) (
	input  logic               clk,
	input  pct_pkg::lane_ctl_t ctl,
	input  logic signed [31:0] prod [NUM_LANES],
	output logic               pos
);
	import pct_pkg::*;

	logic signed [SUM_W-1:0] acc;
	logic signed [SUM_W-1:0] sum_s2;

	always_comb begin
		acc = '0;
		for (int i = 0; i < NUM_LANES; i++)
			acc = acc + SUM_W'(prod[i]);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv2)
			sum_s2 <= acc;
	end

	// strictly positive
	assign pos = !sum_s2[SUM_W-1] && (sum_s2 != '0);

endmodule
`default_nettype wire

[verif/pct_outcome_check.sv]
`default_nettype none
module pct_outcome_check #(
	parameter int NUM_FEATURES = pct_pkg::NUM_FEATURES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	pct_item_if   item,
	pct_result_if result,
	pct_cfg_if    cfg,
	output int    fails,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pct_pkg::*;

	localparam int REPORT_CAP = 100;

	typedef struct packed {
		logic               cls;
		logic [1:0]         err;
		logic signed [15:0] wout;
		logic [15:0]        seen;
		logic [15:0]        correct;
	} outcome_t;

	outcome_t           outcome_q[$];
	logic signed [15:0] wgt[NUM_WEIGHTS];
	logic [15:0]        rate;
	logic [15:0]        seen_cnt;
	logic [15:0]        correct_cnt;
	int                 result_seq;
	int                 fail_count = 0;

	assign fails = fail_count;

	task automatic report(input string msg);
		if (fail_count < REPORT_CAP) begin
			$display("outcome_check: %s", msg);
		end
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report($sformatf("result %0d %s: got %h, expected %h", result_seq, name, got,
				want));
		end
	endtask

	// Exact dot product plus the bias weight scaled up to Q16.16.
	function automatic logic guess_class(input logic [MAX_FEATURES-1:0][15:0] x);
		longint acc;
		acc = longint'(wgt[BIAS_IDX]) * 256;
		for (int i = 0; i < NUM_FEATURES; i++) begin
			acc += longint'($signed(x[i])) * longint'(wgt[i]);
		end
		return acc > 0;
	endfunction

	// One weight moved by rate * x, magnitude rounded half away from zero, saturated.
	function automatic logic signed [15:0] nudge(input logic signed [15:0] w,
			input logic signed [15:0] x, input logic err_neg);
		longint xv;
		longint mag;
		longint sum;
		xv = x;
		mag = (longint'(rate) * (xv < 0 ? -xv : xv) + 32768) >>> 16;
		if ((xv < 0) != err_neg) begin
			mag = -mag;
		end
		sum = longint'(w) + mag;
		if (sum > 32767) begin
			return 16'sh7FFF;
		end else if (sum < -32768) begin
			return 16'sh8000;
		end
		return 16'(sum);
	endfunction

	task automatic absorb_item;
		logic [MAX_FEATURES-1:0][15:0] x;
		outcome_t o;
		x = {item.feature_7, item.feature_6, item.feature_5, item.feature_4,
			item.feature_3, item.feature_2, item.feature_1, item.feature_0};
		o = '0;
		case (item.cmd)
			CMD_CLASSIFY: begin
				o.cls = guess_class(x);
			end
			CMD_TRAIN: begin
				o.cls = guess_class(x);
				if (seen_cnt != 16'hFFFF) begin
					seen_cnt++;
				end
				if (item.label == o.cls) begin
					o.err = ERR_ZERO;
					if (correct_cnt != 16'hFFFF) begin
						correct_cnt++;
					end
				end else begin
					o.err = item.label ? ERR_POS : ERR_NEG;
					for (int i = 0; i < NUM_FEATURES; i++) begin
						wgt[i] = nudge(wgt[i], $signed(x[i]), o.err == ERR_NEG);
					end
					wgt[BIAS_IDX] = nudge(wgt[BIAS_IDX], BIAS_X, o.err == ERR_NEG);
				end
			end
			CMD_WRITE: begin
				if (item.weight_index < NUM_WEIGHTS) begin
					wgt[item.weight_index] = item.weight_value;
					o.wout = item.weight_value;
				end
			end
			CMD_READ: begin
				if (item.weight_index < NUM_WEIGHTS) begin
					o.wout = wgt[item.weight_index];
				end
			end
			CMD_CLEAR: begin
				seen_cnt = '0;
				correct_cnt = '0;
			end
			default: begin
			end
		endcase
		o.seen = seen_cnt;
		o.correct = correct_cnt;
		outcome_q.push_back(o);
	endtask

	task automatic compare_result;
		outcome_t want;
		if (outcome_q.size() == 0) begin
			report($sformatf("result %0d arrived with no item outstanding", result_seq));
		end else begin
			want = outcome_q.pop_front();
			check_field("class_out", {15'd0, result.class_out}, {15'd0, want.cls});
			check_field("error_out", {14'd0, result.error_out}, {14'd0, want.err});
			check_field("weight_out", result.weight_out, want.wout);
			check_field("examples_seen", result.examples_seen, want.seen);
			check_field("examples_correct", result.examples_correct, want.correct);
		end
		result_seq++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				wgt[i] = '0;
			end
			rate = LR_RESET;
			seen_cnt = '0;
			correct_cnt = '0;
			result_seq = 0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			// Results belong to earlier items, so retire before taking a new one.
			if (result.valid && result.ready) begin
				compare_result();
			end
			if (cfg.valid && cfg.ready) begin
				rate = cfg.data;
			end
			if (item.valid && item.ready) begin
				absorb_item();
			end
			pending <= outcome_q.size();
		end
	end
endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pct_pkg::*;

	localparam int LIMIT       = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 170;
	localparam logic [2:0] CMD_TOP = 3'd7;
	localparam logic [3:0] IDX_TOP = 4'hF;
	localparam logic [15:0] EDGE_WORDS[6] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000,
		16'h0001, 16'h0100};
	localparam logic [15:0] PHASE_RATES[PHASES] = '{16'hFFFF, 16'h0000, 16'h0001,
		16'h8000, 16'h0040, 16'h0010, 16'h1000, LR_RESET};

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;

	bit          hold_req;
	bit          stall_mode;
	logic [15:0] ready_pat = 16'hA5F3;
	int          pat_age;
	int          gap_max;
	int          burst_left;
	int          quiet;
	int          n_class;
	int          n_train;
	int          n_weight;
	int          n_misc;
	int          n_rates;

	pct_item_if   item_ch();
	pct_result_if result_ch();
	pct_cfg_if    cfg_ch();

	perceptron_classify_train_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	pct_outcome_check outcome_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.fails   (fails),
		.pending (pending)
	);

	always #6 clk = ~clk;

	// Receiver: always ready, its own stall pattern in stall mode, or one long hold-off on request.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (!stall_mode) begin
				result_ch.ready = 1'b1;
			end else begin
				result_ch.ready = ready_pat[0];
				ready_pat = {ready_pat[0], ready_pat[15:1]};
				pat_age++;
				if (pat_age == 48) begin
					pat_age = 0;
					ready_pat = 16'($urandom) | 16'h0001;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [15:0] rand_word();
		logic [15:0] w;
		case ($urandom_range(3))
			0: w = 16'($urandom);
			1: w = 16'(int'($urandom_range(2048)) - 1024);
			2: w = EDGE_WORDS[$urandom_range(5)];
			default: w = 16'(int'($urandom_range(512)) - 256);
		endcase
		return w;
	endfunction

	task automatic push_item(input logic [2:0] c, input logic [MAX_FEATURES-1:0][15:0] x,
			input logic lbl, input logic [3:0] idx, input logic [15:0] val);
		@(negedge clk);
		item_ch.valid = 1'b1;
		item_ch.cmd = c;
		item_ch.feature_0 = x[0];
		item_ch.feature_1 = x[1];
		item_ch.feature_2 = x[2];
		item_ch.feature_3 = x[3];
		item_ch.feature_4 = x[4];
		item_ch.feature_5 = x[5];
		item_ch.feature_6 = x[6];
		item_ch.feature_7 = x[7];
		item_ch.label = lbl;
		item_ch.weight_index = idx;
		item_ch.weight_value = val;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		case (c)
			CMD_CLASSIFY: n_class++;
			CMD_TRAIN: n_train++;
			CMD_WRITE, CMD_READ: n_weight++;
			default: n_misc++;
		endcase
	endtask

	task automatic idle_items(input int n);
		repeat (n) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
			item_ch.cmd = 3'($urandom);
		end
	endtask

	// Bursts of random length separated by random gaps; gap_max 0 means back to back.
	task automatic pace;
		if (gap_max != 0) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				idle_items($urandom_range(1, gap_max));
				burst_left = $urandom_range(15);
			end
		end
	endtask

	task automatic rand_item;
		logic [MAX_FEATURES-1:0][15:0] x;
		logic [2:0] c;
		logic [3:0] idx;
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			c = CMD_TRAIN;
		end else if (r < 70) begin
			c = CMD_CLASSIFY;
		end else if (r < 78) begin
			c = CMD_WRITE;
		end else if (r < 90) begin
			c = CMD_READ;
		end else if (r < 94) begin
			c = CMD_CLEAR;
		end else begin
			c = 3'($urandom_range(CMD_CLEAR + 1, CMD_TOP));
		end
		for (int i = 0; i < MAX_FEATURES; i++) begin
			x[i] = rand_word();
		end
		if ($urandom_range(9) != 0) begin
			idx = 4'($urandom_range(NUM_WEIGHTS - 1));
		end else begin
			idx = 4'($urandom_range(NUM_WEIGHTS, IDX_TOP));
		end
		push_item(c, x, 1'($urandom_range(1)), idx, rand_word());
	endtask

	task automatic write_rate(input logic [15:0] r);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = r;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		n_rates++;
	endtask

	task automatic drain;
		idle_items(1);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic directed_items;
		logic [MAX_FEATURES-1:0][15:0] zero;
		logic [MAX_FEATURES-1:0][15:0] top;
		logic [MAX_FEATURES-1:0][15:0] bottom;
		logic [MAX_FEATURES-1:0][15:0] mixed;
		zero = '0;
		top = {MAX_FEATURES{16'h7FFF}};
		bottom = {MAX_FEATURES{16'h8000}};
		mixed = {(MAX_FEATURES / 2){16'h7FFF, 16'h8000}};
		push_item(CMD_READ, zero, 1'b0, 4'd0, 16'h0);
		// zero sum is not positive
		push_item(CMD_CLASSIFY, zero, 1'b1, 4'd0, 16'h0);
		push_item(CMD_WRITE, zero, 1'b0, BIAS_IDX, 16'h0001);
		push_item(CMD_CLASSIFY, zero, 1'b0, 4'd0, 16'h0);
		push_item(CMD_WRITE, zero, 1'b0, 4'd0, 16'h7FFF);
		push_item(CMD_WRITE, zero, 1'b0, 4'd7, 16'h8000);
		push_item(CMD_CLASSIFY, top, 1'b0, 4'd0, 16'h0);
		push_item(CMD_CLASSIFY, bottom, 1'b0, 4'd0, 16'h0);
		push_item(CMD_TRAIN, top, 1'b0, 4'd0, 16'h0);
		push_item(CMD_TRAIN, bottom, 1'b1, 4'd0, 16'h0);
		push_item(CMD_TRAIN, mixed, 1'b1, 4'd0, 16'h0);
		push_item(CMD_TRAIN, zero, 1'b0, 4'd0, 16'h0);
		push_item(CMD_READ, zero, 1'b0, 4'd0, 16'h0);
		push_item(CMD_READ, zero, 1'b0, 4'd7, 16'h0);
		push_item(CMD_READ, zero, 1'b0, BIAS_IDX, 16'h0);
		// out-of-range index: write is dropped, read answers zero
		push_item(CMD_WRITE, top, 1'b1, 4'(NUM_WEIGHTS), 16'h1234);
		push_item(CMD_READ, zero, 1'b0, 4'(NUM_WEIGHTS), 16'h0);
		push_item(CMD_READ, zero, 1'b0, IDX_TOP, 16'hFFFF);
		push_item(3'(CMD_CLEAR + 1), top, 1'b1, BIAS_IDX, 16'hFFFF);
		push_item(CMD_TOP, bottom, 1'b1, IDX_TOP, 16'h8000);
		push_item(CMD_CLEAR, zero, 1'b0, 4'd0, 16'h0);
		push_item(CMD_TRAIN, {MAX_FEATURES{16'h0001}}, 1'b1, 4'd0, 16'h0);
		push_item(CMD_TRAIN, {MAX_FEATURES{16'hFFFF}}, 1'b0, 4'd0, 16'h0);
		push_item(CMD_READ, zero, 1'b0, BIAS_IDX, 16'h0);
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_CLASSIFY;
		item_ch.feature_0 = '0;
		item_ch.feature_1 = '0;
		item_ch.feature_2 = '0;
		item_ch.feature_3 = '0;
		item_ch.feature_4 = '0;
		item_ch.feature_5 = '0;
		item_ch.feature_6 = '0;
		item_ch.feature_7 = '0;
		item_ch.label = 1'b0;
		item_ch.weight_index = '0;
		item_ch.weight_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_items();
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_rate((ph == 4 || ph == 6) ? 16'($urandom) : PHASE_RATES[ph]);
			stall_mode = (ph % 3) != 0;
			gap_max = (ph % 4 == 1 || ph == 2) ? 0 : $urandom_range(2, 8);
			burst_left = 0;
			// fill the pipeline against a stalled receiver
			if (ph == 2) begin
				hold_req = 1'b1;
			end
			repeat (PHASE_ITEMS) begin
				rand_item();
				pace();
			end
		end
		drain();
		repeat (10) @(posedge clk);

		$display("tb_top: %0d classify, %0d train, %0d weight access, %0d clear or unknown",
			n_class, n_train, n_weight, n_misc);
		$display("tb_top: %0d learning rates, stray indexes, one %0d-cycle hold-off",
			n_rates, HOLD_CYCLES);
		if (fails == 0 && pending == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
